FILE: hdl/matrix4_general_inverse_defines.svh
// ----------------------------------------------------------------------------
// matrix4_general_inverse_defines
// Assertion macros shared by the 4x4 inverse block.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_GENERAL_INVERSE_DEFINES_SVH
`define MATRIX4_GENERAL_INVERSE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define M4I_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("m4inv check failed");

// next-cycle implication, sampled on clk, off during reset
`define M4I_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("m4inv sequencing check failed");

`endif

FILE: hdl/m4inv_pkg.sv
// ----------------------------------------------------------------------------
// m4inv_pkg
// Widths, constants and permutation tables of the 4x4 adjugate inverse.
// ----------------------------------------------------------------------------
package m4inv_pkg;

	// element format
	localparam int MDIM      = 4;
	localparam int CELLS     = MDIM * MDIM;
	localparam int IDX_W     = $clog2(MDIM);
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int ELEM_W    = 32;
	localparam int FRAC_W    = 16;

	// derived arithmetic widths
	localparam int COF_MAG_W = (MDIM - 1) * ELEM_W;        // 3x3 minor magnitude
	localparam int LIMBS     = COF_MAG_W / ELEM_W;
	localparam int PROD_W    = COF_MAG_W + ELEM_W;
	localparam int ACC_W     = COF_MAG_W + 1;              // signed cofactor
	localparam int DET_MAG_W = COF_MAG_W + ELEM_W + 1;
	localparam int DET_W     = DET_MAG_W + 1;              // signed determinant
	localparam int QUO_W     = ELEM_W + 1;                 // quotient magnitude bits
	localparam int NUM_W     = COF_MAG_W + 2 * FRAC_W;
	localparam int REM_W     = DET_MAG_W + QUO_W;

	localparam int TERMS     = 6;                          // terms of a 3x3 determinant
	localparam int TERM_W    = $clog2(TERMS);

	// odd permutations of the Leibniz expansion
	localparam logic [7:0] PERM_NEG = 8'b0010_0110;

	// column slot of factor f in term t
	function automatic logic [IDX_W-1:0] perm_col(input logic [TERM_W-1:0] t,
			input logic [1:0] f);
		logic [7:0] cols;
		case (t)
			3'd0:    cols = 8'b00_10_01_00;
			3'd1:    cols = 8'b00_01_10_00;
			3'd2:    cols = 8'b00_10_00_01;
			3'd3:    cols = 8'b00_00_10_01;
			3'd4:    cols = 8'b00_01_00_10;
			3'd5:    cols = 8'b00_00_01_10;
			default: cols = 8'b0;
		endcase
		return cols[f*2 +: 2];
	endfunction

	// slot p of the list 0..MDIM-1 with entry x removed
	function automatic logic [IDX_W-1:0] skip_idx(input logic [IDX_W-1:0] p,
			input logic [IDX_W-1:0] x);
		return (p < x) ? p : IDX_W'(p + 1'b1);
	endfunction

endpackage

FILE: hdl/m4inv_mul.sv
// ----------------------------------------------------------------------------
// m4inv_mul
// Limb-serial unsigned multiplier: wide magnitude times one element magnitude,
// one 32x32 partial product per cycle, registered before accumulation.
// ----------------------------------------------------------------------------
module m4inv_mul import m4inv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [COF_MAG_W-1:0] a,
	input  logic [ELEM_W-1:0]    b,
	output logic                 done,
	output logic [PROD_W-1:0]    prod
);

	localparam int LIMB_IW = $clog2(LIMBS);

	logic                 busy_q;
	logic [LIMB_IW-1:0]   cnt_q;
	logic [COF_MAG_W-1:0] a_q;
	logic [ELEM_W-1:0]    b_q;
	logic [2*ELEM_W-1:0]  pp_s1;
	logic                 pp_vld_s1;
	logic [LIMB_IW-1:0]   pp_idx_s1;
	logic [PROD_W-1:0]    prod_q;
	logic                 done_q;
	logic [PROD_W-1:0]    pp_shift;

	// partial product placed at its limb
	assign pp_shift = {{(PROD_W-2*ELEM_W){1'b0}}, pp_s1} << (pp_idx_s1 * ELEM_W);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			pp_vld_s1 <= 1'b0;
			pp_idx_s1 <= '0;
			done_q    <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LIMB_IW'(LIMBS - 1))
					busy_q <= 1'b0;
			end
			pp_vld_s1 <= busy_q;
			pp_idx_s1 <= cnt_q;
			done_q    <= pp_vld_s1 && (pp_idx_s1 == LIMB_IW'(LIMBS - 1));
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= '0;
		end else if (pp_vld_s1) begin
			prod_q <= prod_q + pp_shift;
		end
		if (busy_q)
			pp_s1 <= a_q[cnt_q*ELEM_W +: ELEM_W] * b_q;
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

FILE: hdl/m4inv_div.sv
// ----------------------------------------------------------------------------
// m4inv_div
// Restoring divider, one quotient bit per cycle, with signed saturation of
// the truncated quotient to the element range.
// ----------------------------------------------------------------------------
module m4inv_div import m4inv_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [COF_MAG_W-1:0] num_mag,
	input  logic [DET_MAG_W-1:0] den_mag,
	input  logic                 neg,
	output logic                 done,
	output logic [ELEM_W-1:0]    value,
	output logic                 sat
);

	localparam int STEP_W = $clog2(QUO_W + 1);
	localparam logic [ELEM_W-1:0] MAXV = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic [ELEM_W-1:0] MINV = {1'b1, {(ELEM_W-1){1'b0}}};

	logic               busy_q;
	logic               fin_q;
	logic               done_q;
	logic [STEP_W-1:0]  step_q;
	logic [REM_W-1:0]   rem_q;
	logic [REM_W-1:0]   dsh_q;
	logic [QUO_W-1:0]   quo_q;
	logic               ovf_q;
	logic               neg_q;
	logic [ELEM_W-1:0]  value_q;
	logic               sat_q;
	logic [REM_W:0]     trial;
	logic               ge;
	logic               pos_over;
	logic               neg_over;

	assign trial = {1'b0, rem_q} - {1'b0, dsh_q};
	assign ge    = !trial[REM_W];

	// quotient magnitude above the positive / negative bound
	assign pos_over = quo_q[QUO_W-1] | quo_q[ELEM_W-1];
	assign neg_over = quo_q[QUO_W-1] | (quo_q[ELEM_W-1] & (|quo_q[ELEM_W-2:0]));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q  <= busy_q && !start && (step_q == '0);
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(QUO_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0)
					busy_q <= 1'b0;
			end
		end
	end

	// datapath: first step only tests for overflow, the rest build the quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(REM_W-NUM_W){1'b0}}, num_mag, {(2*FRAC_W){1'b0}}};
			dsh_q <= {den_mag, {QUO_W{1'b0}}};
			quo_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= neg;
		end else if (busy_q) begin
			dsh_q <= dsh_q >> 1;
			if (step_q == STEP_W'(QUO_W)) begin
				ovf_q <= ge;
			end else begin
				if (ge)
					rem_q <= trial[REM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], ge};
			end
		end
		if (fin_q) begin
			if (ovf_q || (neg_q ? neg_over : pos_over)) begin
				value_q <= neg_q ? MINV : MAXV;
				sat_q   <= 1'b1;
			end else begin
				value_q <= neg_q ? (~quo_q[ELEM_W-1:0] + 1'b1) : quo_q[ELEM_W-1:0];
				sat_q   <= 1'b0;
			end
		end
	end

	assign done  = done_q;
	assign value = value_q;
	assign sat   = sat_q;

endmodule

FILE: hdl/matrix4_general_inverse.sv
// Sequence: after the 16th element transfer, all cofactors and the determinant are
//   computed (18 element products per cofactor, one more per row-0 cofactor), then
//   each result is divided out (no division if singular) and passed to the output.
// Input stalls outside loading: a new matrix is taken only after its last result is passed on.
// Reset: load count and sequencer return to loading, output empty; the element
//   and cofactor stores are not cleared.
// ----------------------------------------------------------------------------
// matrix4_general_inverse
// 4x4 inverse by the adjugate: element store, cofactor store, sequencer,
// shared multiplier and divider.
// ----------------------------------------------------------------------------
`include "matrix4_general_inverse_defines.svh"

module matrix4_general_inverse import m4inv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ELEM_W-1:0] matrix_element,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ELEM_W-1:0] inverse_element,
	output logic              singular,
	output logic              saturated,
	output logic              last_result
);

	// sequencer states
	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_RD    = 4'd1;
	localparam logic [3:0] ST_GO    = 4'd2;
	localparam logic [3:0] ST_WAIT  = 4'd3;
	localparam logic [3:0] ST_CFIN  = 4'd4;
	localparam logic [3:0] ST_QRD   = 4'd5;
	localparam logic [3:0] ST_QGO   = 4'd6;
	localparam logic [3:0] ST_QWAIT = 4'd7;
	localparam logic [3:0] ST_EMIT  = 4'd8;

	localparam logic [ADDR_W-1:0] LOAD_LAST = ADDR_W'(CELLS - 1);
	localparam logic [1:0]        FAC_DET   = 2'd3;
	localparam logic [1:0]        FAC_LAST  = 2'd2;

	// stores
	logic [ELEM_W-1:0] elem_mem [CELLS];
	logic [ACC_W-1:0]  cof_mem  [CELLS];   // {sign, magnitude}, adjugate order

	logic [3:0]              state_q;
	logic [ADDR_W-1:0]       load_q;
	logic [ADDR_W-1:0]       cidx_q;
	logic [TERM_W-1:0]       term_q;
	logic [1:0]              fac_q;
	logic [ADDR_W-1:0]       k_q;
	logic [COF_MAG_W-1:0]    m_q;
	logic                    msign_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [DET_W-1:0] det_q;
	logic [DET_MAG_W-1:0]    det_mag_q;
	logic                    det_neg_q;
	logic                    det_zero_q;
	logic [ELEM_W-1:0]       rd_q;
	logic [ACC_W-1:0]        crd_q;
	logic [ELEM_W-1:0]       res_val_q;
	logic                    res_sat_q;
	logic                    res_sing_q;
	logic                    out_valid_q;
	logic [ELEM_W-1:0]       inv_q;
	logic                    sing_q;
	logic                    sat_q;
	logic                    last_q;

	logic                    in_xfer;
	logic                    out_xfer;
	logic                    out_free;
	logic [IDX_W-1:0]        ci;
	logic [IDX_W-1:0]        cj;
	logic [IDX_W-1:0]        row;
	logic [IDX_W-1:0]        col;
	logic [ADDR_W-1:0]       rd_addr;
	logic                    rd_neg;
	logic [ELEM_W-1:0]       rd_mag;
	logic                    mul_done;
	logic [PROD_W-1:0]       mul_prod;
	logic signed [ACC_W-1:0] prod_a;
	logic signed [DET_W-1:0] prod_d;
	logic signed [ACC_W-1:0] cof_s;
	logic                    cof_neg;
	logic [COF_MAG_W-1:0]    cof_mag;
	logic signed [DET_W-1:0] det_abs;
	logic                    div_done;
	logic [ELEM_W-1:0]       div_value;
	logic                    div_sat;

	assign in_stall = (state_q != ST_LOAD);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	// element address of the current factor
	assign ci      = cidx_q[ADDR_W-1 -: IDX_W];
	assign cj      = cidx_q[IDX_W-1:0];
	assign row     = skip_idx(fac_q, ci);
	assign col     = skip_idx(perm_col(term_q, fac_q), cj);
	assign rd_addr = (fac_q == FAC_DET) ? {{(ADDR_W-IDX_W){1'b0}}, cj} : {row, col};

	assign rd_neg  = rd_q[ELEM_W-1];
	assign rd_mag  = rd_neg ? (~rd_q + 1'b1) : rd_q;

	assign prod_a  = $signed({1'b0, mul_prod[ACC_W-2:0]});
	assign prod_d  = $signed({{(DET_W-PROD_W){1'b0}}, mul_prod});

	// finished cofactor with its checkerboard sign
	assign cof_s   = (ci[0] ^ cj[0]) ? -acc_q : acc_q;
	assign cof_neg = cof_s[ACC_W-1];
	assign cof_mag = cof_neg ? COF_MAG_W'(-cof_s) : cof_s[COF_MAG_W-1:0];
	assign det_abs = det_q[DET_W-1] ? -det_q : det_q;

	// element store
	always_ff @(posedge clk) begin
		if (in_xfer)
			elem_mem[load_q] <= matrix_element;
		rd_q <= elem_mem[rd_addr];
	end

	// cofactor store, written transposed
	always_ff @(posedge clk) begin
		if (state_q == ST_CFIN)
			cof_mem[{cj, ci}] <= {cof_neg, cof_mag};
		crd_q <= cof_mem[k_q];
	end

	m4inv_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_GO),
		.a      (m_q),
		.b      (rd_mag),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	m4inv_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   ((state_q == ST_QGO) && !det_zero_q),
		.num_mag (crd_q[COF_MAG_W-1:0]),
		.den_mag (det_mag_q),
		.neg     (crd_q[COF_MAG_W] ^ det_neg_q),
		.done    (div_done),
		.value   (div_value),
		.sat     (div_sat)
	);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_q      <= '0;
			cidx_q      <= '0;
			term_q      <= '0;
			fac_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						// wraps to zero after the last element
						load_q <= load_q + 1'b1;
						if (load_q == LOAD_LAST) begin
							cidx_q  <= '0;
							term_q  <= '0;
							fac_q   <= '0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD:   state_q <= ST_GO;
				ST_GO:   state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mul_done) begin
						if (fac_q == FAC_DET) begin
							cidx_q  <= cidx_q + 1'b1;
							term_q  <= '0;
							fac_q   <= '0;
							state_q <= ST_RD;
						end else if (fac_q == FAC_LAST) begin
							if (term_q == TERM_W'(TERMS - 1)) begin
								state_q <= ST_CFIN;
							end else begin
								term_q  <= term_q + 1'b1;
								fac_q   <= '0;
								state_q <= ST_RD;
							end
						end else begin
							fac_q   <= fac_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_CFIN: begin
					if (ci == '0) begin
						fac_q   <= FAC_DET;
						state_q <= ST_RD;
					end else if (cidx_q == LOAD_LAST) begin
						k_q     <= '0;
						state_q <= ST_QRD;
					end else begin
						cidx_q  <= cidx_q + 1'b1;
						term_q  <= '0;
						fac_q   <= '0;
						state_q <= ST_RD;
					end
				end
				ST_QRD:  state_q <= ST_QGO;
				ST_QGO:  state_q <= det_zero_q ? ST_EMIT : ST_QWAIT;
				ST_QWAIT: begin
					if (div_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (k_q == LOAD_LAST) begin
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_QRD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// arithmetic state
	always_ff @(posedge clk) begin
		// a new matrix starts with a cleared determinant and accumulator and a unit running product
		if ((state_q == ST_LOAD) && in_xfer && (load_q == LOAD_LAST)) begin
			det_q   <= '0;
			acc_q   <= '0;
			m_q     <= COF_MAG_W'(1);
			msign_q <= PERM_NEG[0];
		end
		if (state_q == ST_GO)
			msign_q <= msign_q ^ rd_neg;
		if ((state_q == ST_WAIT) && mul_done) begin
			if (fac_q == FAC_DET) begin
				det_q   <= msign_q ? (det_q - prod_d) : (det_q + prod_d);
				acc_q   <= '0;
				m_q     <= COF_MAG_W'(1);
				msign_q <= PERM_NEG[0];
			end else if (fac_q == FAC_LAST) begin
				acc_q   <= msign_q ? (acc_q - prod_a) : (acc_q + prod_a);
				m_q     <= COF_MAG_W'(1);
				msign_q <= PERM_NEG[TERM_W'(term_q + 1'b1)];
			end else begin
				m_q <= mul_prod[COF_MAG_W-1:0];
			end
		end
		if (state_q == ST_CFIN) begin
			if (ci == '0) begin
				m_q     <= cof_mag;
				msign_q <= cof_neg;
			end else begin
				acc_q   <= '0;
				m_q     <= COF_MAG_W'(1);
				msign_q <= PERM_NEG[0];
			end
			det_mag_q  <= det_abs[DET_MAG_W-1:0];
			det_neg_q  <= det_q[DET_W-1];
			det_zero_q <= (det_q == '0);
		end
		// per-element result
		if ((state_q == ST_QGO) && det_zero_q) begin
			res_val_q  <= '0;
			res_sat_q  <= 1'b0;
			res_sing_q <= 1'b1;
		end
		if ((state_q == ST_QWAIT) && div_done) begin
			res_val_q  <= div_value;
			res_sat_q  <= div_sat;
			res_sing_q <= 1'b0;
		end
		// output register
		if ((state_q == ST_EMIT) && out_free) begin
			inv_q  <= res_val_q;
			sat_q  <= res_sat_q;
			sing_q <= res_sing_q;
			last_q <= (k_q == LOAD_LAST);
		end
	end

	assign out_valid       = out_valid_q;
	assign inverse_element = inv_q;
	assign singular        = sing_q;
	assign saturated       = sat_q;
	assign last_result     = last_q;

	// checks
	`M4I_ASSERT_IMPL(a_mul_done_wait, mul_done, state_q == ST_WAIT)
	`M4I_ASSERT_IMPL(a_div_done_wait, div_done, state_q == ST_QWAIT)
	`M4I_ASSERT_IMPL(a_load_idle, state_q != ST_LOAD, load_q == '0)
	`M4I_ASSERT_IMPL(a_singular_zero, out_valid_q && sing_q, (inv_q == '0) && !sat_q)
	`M4I_ASSERT_NEXT(a_load_done, in_xfer && (load_q == LOAD_LAST), state_q == ST_RD)

endmodule
